// ===== src/lbcs_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the line band centroid steering block.
// No dependencies; imported by every module of the block except lbcs_div.
package lbcs_pkg;

	// field widths
	localparam int PIX_W    = 8;
	localparam int FW_CFG_W = 12;
	localparam int BH_CFG_W = 7;
	localparam int VM_CFG_W = 8;
	localparam int SG_CFG_W = 12;
	localparam int CS_CFG_W = 16;
	localparam int CX_W     = 11;
	localparam int CY_W     = 11;
	localparam int ANG_W    = 19;
	localparam int LIN_W    = 16;

	// register indexes on the configuration port
	localparam logic [2:0] REG_FRAME_WIDTH  = 3'd0;
	localparam logic [2:0] REG_FRAME_HEIGHT = 3'd1;
	localparam logic [2:0] REG_BAND_HEIGHT  = 3'd2;
	localparam logic [2:0] REG_VALUE_MAX    = 3'd3;
	localparam logic [2:0] REG_STEER_GAIN   = 3'd4;
	localparam logic [2:0] REG_CRUISE_SPEED = 3'd5;

	// register reset values
	localparam logic [FW_CFG_W-1:0] RST_FRAME_WIDTH  = 12'd640;
	localparam logic [FW_CFG_W-1:0] RST_FRAME_HEIGHT = 12'd480;
	localparam logic [BH_CFG_W-1:0] RST_BAND_HEIGHT  = 7'd20;
	localparam logic [VM_CFG_W-1:0] RST_VALUE_MAX    = 8'd46;
	localparam logic [SG_CFG_W-1:0] RST_STEER_GAIN   = 12'd1398;
	localparam logic [CS_CFG_W-1:0] RST_CRUISE_SPEED = 16'd6554;

	// steering: Q20 product to Q16, rounded half away from zero
	localparam int STEER_SHIFT = 4;
	localparam int STEER_HALF  = 8;
	localparam logic [31:0] ANG_POS_LIM = 32'd262143;
	localparam logic [31:0] ANG_NEG_LIM = 32'd262144;
	localparam logic signed [ANG_W-1:0] ANG_MAX_V = 19'sh3FFFF;
	localparam logic signed [ANG_W-1:0] ANG_MIN_V = 19'sh40000;

	typedef enum logic [2:0] {
		ST_PIX,
		ST_XSTART,
		ST_XWAIT,
		ST_YSTART,
		ST_YWAIT,
		ST_MUL,
		ST_LOAD
	} lbcs_state_t;

	typedef struct packed {
		logic pix_en;
		logic div_start;
		logic div_sel_y;
		logic cap_x;
		logic cap_y;
		logic mul_en;
		logic load_out;
	} lbcs_cmd_t;

	typedef struct packed {
		logic pix_acc;
		logic pix_last;
		logic div_busy;
		logic div_done;
		logic out_free;
	} lbcs_stat_t;

endpackage

// ===== src/lbcs_div.sv =====
`timescale 1ns / 1ps
// Restoring divider, one quotient bit per cycle, with remainder.
// Stand-alone; used by lbcs_dp for the centroid divisions.
module lbcs_div #(
	parameter int NUM_W = 33,
	parameter int DEN_W = 23
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	output logic [NUM_W-1:0] quo,
	output logic [DEN_W-1:0] rem,
	output logic             busy,
	output logic             done
);

	localparam int CNT_W = $clog2(NUM_W + 1);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [NUM_W-1:0] quo_q;
	logic [DEN_W-1:0] rem_q;
	logic [DEN_W-1:0] den_q;

	logic [DEN_W:0]   part;
	logic [DEN_W:0]   diff;
	logic             ge;

	always_comb begin
		part = {rem_q, quo_q[NUM_W-1]};
		diff = part - {1'b0, den_q};
		ge   = (part >= {1'b0, den_q});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(NUM_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= num;
			rem_q <= '0;
			den_q <= den;
		end else if (busy_q) begin
			rem_q <= ge ? diff[DEN_W-1:0] : part[DEN_W-1:0];
			quo_q <= {quo_q[NUM_W-2:0], ge};
		end
	end

	assign quo  = quo_q;
	assign rem  = rem_q;
	assign busy = busy_q;
	assign done = done_q;

endmodule

// ===== src/lbcs_dp.sv =====
`timescale 1ns / 1ps
// Datapath: pixel classification, band accumulation, centroid rounding,
// steering product and result register. Uses lbcs_pkg and lbcs_div.
module lbcs_dp
	import lbcs_pkg::*;
#(
	parameter int MAX_WIDTH  = 2048,
	parameter int MAX_HEIGHT = 2048,
	parameter int MAX_BAND   = 64
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  lbcs_cmd_t                  cmd,
	output lbcs_stat_t                 stat,
	input  logic                       in_valid,
	input  logic [PIX_W-1:0]           blue,
	input  logic [PIX_W-1:0]           green,
	input  logic [PIX_W-1:0]           red,
	input  logic                       frame_start,
	input  logic [FW_CFG_W-1:0]        frame_width,
	input  logic [FW_CFG_W-1:0]        frame_height,
	input  logic [BH_CFG_W-1:0]        band_height,
	input  logic [VM_CFG_W-1:0]        value_max,
	input  logic [SG_CFG_W-1:0]        steer_gain,
	input  logic [CS_CFG_W-1:0]        cruise_speed,
	input  logic                       out_ready,
	output logic                       out_valid,
	output logic                       line_found,
	output logic [CX_W-1:0]            centroid_x,
	output logic [CY_W-1:0]            centroid_y,
	output logic signed [ANG_W-1:0]    angular_cmd,
	output logic [LIN_W-1:0]           linear_cmd
);

	localparam int XW    = $clog2(MAX_WIDTH);
	localparam int YW    = $clog2(MAX_HEIGHT);
	localparam int CW    = $clog2(MAX_WIDTH + 1);
	localparam int HW    = $clog2(MAX_HEIGHT + 1);
	localparam int BW    = $clog2(MAX_BAND + 1);
	localparam int TBW   = ((HW > BW) ? HW : BW) + 1;
	localparam int DCW   = XW + YW + 1;
	localparam int MXW   = (XW > YW) ? XW : YW;
	localparam int SUM_W = XW + YW + MXW;
	localparam int OFFW  = XW + 2;
	localparam int PW    = OFFW + SG_CFG_W + 1;
	localparam int RQW   = PW + 1 - STEER_SHIFT;

	// effective geometry
	logic [CW-1:0]  w_eff;
	logic [HW-1:0]  h_eff;
	logic [BW-1:0]  band_eff;
	logic [HW+1:0]  h3;
	logic [HW-1:0]  top;
	logic [TBW-1:0] band_end;

	always_comb begin
		if (frame_width == '0) begin
			w_eff = CW'(1);
		end else if (32'(frame_width) > 32'(MAX_WIDTH)) begin
			w_eff = CW'(MAX_WIDTH);
		end else begin
			w_eff = CW'(frame_width);
		end
		if (frame_height == '0) begin
			h_eff = HW'(1);
		end else if (32'(frame_height) > 32'(MAX_HEIGHT)) begin
			h_eff = HW'(MAX_HEIGHT);
		end else begin
			h_eff = HW'(frame_height);
		end
		if (32'(band_height) > 32'(MAX_BAND)) begin
			band_eff = BW'(MAX_BAND);
		end else begin
			band_eff = BW'(band_height);
		end
		h3       = (HW+2)'(h_eff) + (HW+2)'({h_eff, 1'b0});
		top      = h3[HW+1:2];
		band_end = TBW'(top) + TBW'(band_eff);
	end

	// frame accumulators
	logic [XW-1:0]    col_q;
	logic [YW-1:0]    row_q;
	logic [DCW-1:0]   dark_q;
	logic [SUM_W-1:0] sx_q;
	logic [SUM_W-1:0] sy_q;
	logic             new_frame_q;

	logic             clr;
	logic [XW-1:0]    col_c;
	logic [YW-1:0]    row_c;
	logic [DCW-1:0]   dark_c;
	logic [SUM_W-1:0] sx_c;
	logic [SUM_W-1:0] sy_c;
	logic [PIX_W-1:0] vmax;
	logic             hit;
	logic             col_end;
	logic             row_end;
	logic             pix_acc;

	always_comb begin
		clr    = frame_start | new_frame_q;
		col_c  = clr ? '0 : col_q;
		row_c  = clr ? '0 : row_q;
		dark_c = clr ? '0 : dark_q;
		sx_c   = clr ? '0 : sx_q;
		sy_c   = clr ? '0 : sy_q;
		vmax   = blue;
		if (green > vmax) begin
			vmax = green;
		end
		if (red > vmax) begin
			vmax = red;
		end
		hit = (vmax <= value_max) && (TBW'(row_c) >= TBW'(top))
			&& (TBW'(row_c) < band_end);
		col_end = (CW'(col_c) + CW'(1)) >= w_eff;
		row_end = (HW'(row_c) + HW'(1)) >= h_eff;
		pix_acc = in_valid & cmd.pix_en;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q       <= '0;
			row_q       <= '0;
			dark_q      <= '0;
			sx_q        <= '0;
			sy_q        <= '0;
			new_frame_q <= 1'b0;
		end else if (pix_acc) begin
			dark_q      <= dark_c + DCW'(hit);
			sx_q        <= sx_c + (hit ? SUM_W'(col_c) : '0);
			sy_q        <= sy_c + (hit ? SUM_W'(row_c) : '0);
			// totals stay put for the divider; the next word starts a new frame
			new_frame_q <= col_end & row_end;
			if (col_end) begin
				col_q <= '0;
				row_q <= row_end ? '0 : row_c + YW'(1);
			end else begin
				col_q <= col_c + XW'(1);
				row_q <= row_c;
			end
		end
	end

	// centroid divisions, x then y on one divider
	logic [SUM_W-1:0] quo;
	logic [DCW-1:0]   rem;
	logic             div_busy;
	logic             div_done;
	logic             round_up;

	lbcs_div #(
		.NUM_W (SUM_W),
		.DEN_W (DCW)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.div_start),
		.num    (cmd.div_sel_y ? sy_q : sx_q),
		.den    (dark_q),
		.quo    (quo),
		.rem    (rem),
		.busy   (div_busy),
		.done   (div_done)
	);

	always_comb begin
		round_up = ({rem, 1'b0} > {1'b0, dark_q})
			|| (({rem, 1'b0} == {1'b0, dark_q}) && quo[0]);
	end

	logic [XW-1:0]               cx_q;
	logic [YW-1:0]               cy_q;
	logic signed [OFFW-1:0]      off;
	logic signed [PW-1:0]        prod_s1;

	always_comb begin
		off = $signed({2'b00, cx_q}) - $signed({2'b00, XW'(w_eff >> 1)});
	end

	always_ff @(posedge clk) begin
		if (cmd.cap_x) begin
			cx_q <= quo[XW-1:0] + XW'(round_up);
		end
		if (cmd.cap_y) begin
			cy_q <= quo[YW-1:0] + YW'(round_up);
		end
		if (cmd.mul_en) begin
			prod_s1 <= off * $signed({1'b0, steer_gain});
		end
	end

	// round the Q20 product to Q16 and saturate
	logic                    found;
	logic                    neg;
	logic [PW-1:0]           mag;
	logic [PW:0]             mag_r;
	logic [RQW-1:0]          rq;
	logic signed [ANG_W-1:0] ang_new;
	logic signed [ANG_W-1:0] ang_sel;
	logic [LIN_W-1:0]        lin_sel;

	logic signed [ANG_W-1:0] held_ang_q;
	logic [LIN_W-1:0]        held_lin_q;
	logic                    out_valid_q;
	logic                    out_found_q;
	logic [CX_W-1:0]         out_cx_q;
	logic [CY_W-1:0]         out_cy_q;
	logic signed [ANG_W-1:0] out_ang_q;
	logic [LIN_W-1:0]        out_lin_q;

	always_comb begin
		found = (dark_q != '0);
		neg   = (prod_s1 > 0);
		mag   = prod_s1[PW-1] ? PW'(-prod_s1) : PW'(prod_s1);
		mag_r = (PW+1)'(mag) + (PW+1)'(STEER_HALF);
		rq    = mag_r[PW:STEER_SHIFT];
		if (neg) begin
			ang_new = (32'(rq) > ANG_NEG_LIM) ? ANG_MIN_V : -$signed(ANG_W'(rq));
		end else begin
			ang_new = (32'(rq) > ANG_POS_LIM) ? ANG_MAX_V : $signed(ANG_W'(rq));
		end
		ang_sel = found ? ang_new : held_ang_q;
		lin_sel = found ? cruise_speed : held_lin_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_ang_q  <= '0;
			held_lin_q  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.load_out) begin
				held_ang_q  <= ang_sel;
				held_lin_q  <= lin_sel;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			out_found_q <= found;
			out_cx_q    <= found ? CX_W'(cx_q) : '0;
			out_cy_q    <= found ? CY_W'(cy_q) : '0;
			out_ang_q   <= ang_sel;
			out_lin_q   <= lin_sel;
		end
	end

	always_comb begin
		stat.pix_acc  = pix_acc;
		stat.pix_last = col_end & row_end;
		stat.div_busy = div_busy;
		stat.div_done = div_done;
		stat.out_free = ~out_valid_q | out_ready;
	end

	assign out_valid   = out_valid_q;
	assign line_found  = out_found_q;
	assign centroid_x  = out_cx_q;
	assign centroid_y  = out_cy_q;
	assign angular_cmd = out_ang_q;
	assign linear_cmd  = out_lin_q;

endmodule

// ===== src/lbcs_ctrl.sv =====
`timescale 1ns / 1ps
// Controller: sequences pixel intake, the two centroid divisions, the
// steering product and the result load. Uses lbcs_pkg.
module lbcs_ctrl
	import lbcs_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  lbcs_stat_t stat,
	output lbcs_cmd_t  cmd
);

	lbcs_state_t state_q;
	lbcs_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_PIX;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			ST_PIX: begin
				cmd.pix_en = 1'b1;
				if (stat.pix_acc && stat.pix_last) begin
					state_d = ST_XSTART;
				end
			end
			ST_XSTART: begin
				cmd.div_start = 1'b1;
				state_d       = ST_XWAIT;
			end
			ST_XWAIT: begin
				if (stat.div_done) begin
					cmd.cap_x = 1'b1;
					state_d   = ST_YSTART;
				end
			end
			ST_YSTART: begin
				cmd.div_start = 1'b1;
				cmd.div_sel_y = 1'b1;
				state_d       = ST_YWAIT;
			end
			ST_YWAIT: begin
				if (stat.div_done) begin
					cmd.cap_y = 1'b1;
					state_d   = ST_MUL;
				end
			end
			ST_MUL: begin
				cmd.mul_en = 1'b1;
				state_d    = ST_LOAD;
			end
			ST_LOAD: begin
				// hold until the result register is free
				if (stat.out_free) begin
					cmd.load_out = 1'b1;
					state_d      = ST_PIX;
				end
			end
			default: begin
				state_d = ST_PIX;
			end
		endcase
	end

	a_stop_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		(stat.pix_acc && stat.pix_last) |=> !cmd.pix_en)
		else $error("pixel intake not stopped after last word of frame");

	a_done_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		stat.div_done |-> (state_q == ST_XWAIT || state_q == ST_YWAIT))
		else $error("divider finished outside a wait state");

	a_start_idle_div: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_start |-> !stat.div_busy)
		else $error("divider started while busy");

	a_no_pix_while_div: assert property (@(posedge clk) disable iff (!arst_n)
		stat.div_busy |-> !cmd.pix_en)
		else $error("pixel intake open during division");

endmodule

// ===== src/line_band_centroid_steer_top.sv =====
`timescale 1ns / 1ps
// Top level of the dark-line band centroid steering block: stream ports,
// APB register file, lbcs_ctrl and lbcs_dp. Uses lbcs_pkg.
//
// Pixels stream in raster order, one word per cycle while s_tready is high.
// The last pixel of a frame starts the centroid work: the shared restoring
// divider runs once for x and once for y, then the steering product is
// registered and the result register is loaded once it is free. Pixel intake
// pauses during that time; one result word comes out per frame, and the next
// frame may start while it waits to be taken. frame_start on a pixel clears
// the counters for that pixel. Without a dark pixel in the band the previous
// commands are repeated.
module line_band_centroid_steer_top
	import lbcs_pkg::*;
#(
	parameter int MAX_WIDTH  = 2048,
	parameter int MAX_HEIGHT = 2048,
	parameter int MAX_BAND   = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	// APB configuration port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	// pixel stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,   // blue[7:0], green[15:8], red[23:16]
	input  logic        s_tuser,   // frame_start
	// result stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [63:0] m_tdata,   // centroid_x[10:0], centroid_y[21:11],
	                               // angular_cmd[40:22], linear_cmd[56:41], zero
	output logic        m_tuser    // line_found
);

	logic [FW_CFG_W-1:0] frame_width_q;
	logic [FW_CFG_W-1:0] frame_height_q;
	logic [BH_CFG_W-1:0] band_height_q;
	logic [VM_CFG_W-1:0] value_max_q;
	logic [SG_CFG_W-1:0] steer_gain_q;
	logic [CS_CFG_W-1:0] cruise_speed_q;

	logic [2:0] reg_idx;
	logic       reg_wr;

	assign pready  = 1'b1;
	assign reg_idx = paddr[4:2];
	assign reg_wr  = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q  <= RST_FRAME_WIDTH;
			frame_height_q <= RST_FRAME_HEIGHT;
			band_height_q  <= RST_BAND_HEIGHT;
			value_max_q    <= RST_VALUE_MAX;
			steer_gain_q   <= RST_STEER_GAIN;
			cruise_speed_q <= RST_CRUISE_SPEED;
		end else if (reg_wr) begin
			case (reg_idx)
				REG_FRAME_WIDTH:  frame_width_q  <= pwdata[FW_CFG_W-1:0];
				REG_FRAME_HEIGHT: frame_height_q <= pwdata[FW_CFG_W-1:0];
				REG_BAND_HEIGHT:  band_height_q  <= pwdata[BH_CFG_W-1:0];
				REG_VALUE_MAX:    value_max_q    <= pwdata[VM_CFG_W-1:0];
				REG_STEER_GAIN:   steer_gain_q   <= pwdata[SG_CFG_W-1:0];
				REG_CRUISE_SPEED: cruise_speed_q <= pwdata[CS_CFG_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_FRAME_WIDTH:  prdata = 32'(frame_width_q);
			REG_FRAME_HEIGHT: prdata = 32'(frame_height_q);
			REG_BAND_HEIGHT:  prdata = 32'(band_height_q);
			REG_VALUE_MAX:    prdata = 32'(value_max_q);
			REG_STEER_GAIN:   prdata = 32'(steer_gain_q);
			REG_CRUISE_SPEED: prdata = 32'(cruise_speed_q);
			default:          prdata = '0;
		endcase
	end

	lbcs_cmd_t  cmd;
	lbcs_stat_t stat;

	logic                    line_found;
	logic [CX_W-1:0]         centroid_x;
	logic [CY_W-1:0]         centroid_y;
	logic signed [ANG_W-1:0] angular_cmd;
	logic [LIN_W-1:0]        linear_cmd;

	lbcs_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.stat   (stat),
		.cmd    (cmd)
	);

	lbcs_dp #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT),
		.MAX_BAND   (MAX_BAND)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.stat         (stat),
		.in_valid     (s_tvalid),
		.blue         (s_tdata[7:0]),
		.green        (s_tdata[15:8]),
		.red          (s_tdata[23:16]),
		.frame_start  (s_tuser),
		.frame_width  (frame_width_q),
		.frame_height (frame_height_q),
		.band_height  (band_height_q),
		.value_max    (value_max_q),
		.steer_gain   (steer_gain_q),
		.cruise_speed (cruise_speed_q),
		.out_ready    (m_tready),
		.out_valid    (m_tvalid),
		.line_found   (line_found),
		.centroid_x   (centroid_x),
		.centroid_y   (centroid_y),
		.angular_cmd  (angular_cmd),
		.linear_cmd   (linear_cmd)
	);

	assign s_tready = cmd.pix_en;
	assign m_tuser  = line_found;
	assign m_tdata  = {7'd0, linear_cmd, angular_cmd, centroid_y, centroid_x};

endmodule
